FILE: hw/rtl/hrbp_pkg.sv
// Package for the HTTP request byte parser: phase codes, result struct, helpers.
// No dependencies.
`timescale 1ns / 1ps
package hrbp_pkg;
    localparam logic [3:0] PH_METHOD  = 4'd0;
    localparam logic [3:0] PH_PATH    = 4'd1;
    localparam logic [3:0] PH_QUERY   = 4'd2;
    localparam logic [3:0] PH_VERSION = 4'd3;
    localparam logic [3:0] PH_HEADER  = 4'd4;
    localparam logic [3:0] PH_BODY    = 4'd5;
    localparam logic [3:0] PH_CHUNKED = 4'd6;
    localparam logic [3:0] PH_DONE    = 4'd7;
    localparam logic [3:0] PH_ERROR   = 4'd8;

    localparam logic [1:0] CK_SIZE    = 2'd0;
    localparam logic [1:0] CK_DATA    = 2'd1;
    localparam logic [1:0] CK_TRAILER = 2'd2;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_SIZE   = 2'd1;
    localparam logic [1:0] ERR_LENGTH = 2'd2;

    localparam logic [2:0] PART_FRAME   = 3'd0;
    localparam logic [2:0] PART_METHOD  = 3'd1;
    localparam logic [2:0] PART_PATH    = 3'd2;
    localparam logic [2:0] PART_QUERY   = 3'd3;
    localparam logic [2:0] PART_VERSION = 3'd4;
    localparam logic [2:0] PART_HNAME   = 3'd5;
    localparam logic [2:0] PART_HVALUE  = 3'd6;
    localparam logic [2:0] PART_BODY    = 3'd7;

    localparam int LEN_TE = 17;
    localparam int LEN_CL = 14;
    localparam int LEN_CK = 7;
    localparam logic [31:0] MAX_BODY_RESET = 32'd1048576;

    typedef struct packed {
        logic [7:0] byte_out;
        logic [2:0] part;
        logic       field_end;
        logic       headers_done;
        logic       request_done;
        logic [1:0] error_code;
    } t_result;

    function automatic logic [7:0] te_char(input logic [4:0] i);
        case (i)
            5'd0: te_char = "t";   5'd1: te_char = "r";   5'd2: te_char = "a";
            5'd3: te_char = "n";   5'd4: te_char = "s";   5'd5: te_char = "f";
            5'd6: te_char = "e";   5'd7: te_char = "r";   5'd8: te_char = "-";
            5'd9: te_char = "e";   5'd10: te_char = "n";  5'd11: te_char = "c";
            5'd12: te_char = "o";  5'd13: te_char = "d";  5'd14: te_char = "i";
            5'd15: te_char = "n";  5'd16: te_char = "g";
            default: te_char = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] cl_char(input logic [4:0] i);
        case (i)
            5'd0: cl_char = "c";   5'd1: cl_char = "o";   5'd2: cl_char = "n";
            5'd3: cl_char = "t";   5'd4: cl_char = "e";   5'd5: cl_char = "n";
            5'd6: cl_char = "t";   5'd7: cl_char = "-";   5'd8: cl_char = "l";
            5'd9: cl_char = "e";   5'd10: cl_char = "n";  5'd11: cl_char = "g";
            5'd12: cl_char = "t";  5'd13: cl_char = "h";
            default: cl_char = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] ck_char(input logic [2:0] i);
        case (i)
            3'd0: ck_char = "c";  3'd1: ck_char = "h";  3'd2: ck_char = "u";
            3'd3: ck_char = "n";  3'd4: ck_char = "k";  3'd5: ck_char = "e";
            3'd6: ck_char = "d";
            default: ck_char = 8'h00;
        endcase
    endfunction
endpackage

FILE: hw/rtl/hrbp_if.sv
// Valid/ready channel interfaces for the parser's input and output.
// No dependencies.
`timescale 1ns / 1ps
interface hrbp_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;
    modport source (output valid, command, data_byte, input ready);
    modport sink   (input valid, command, data_byte, output ready);
endinterface

interface hrbp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic [2:0] part;
    logic       field_end;
    logic       headers_done;
    logic       request_done;
    logic [1:0] error_code;
    modport source (output valid, byte_out, part, field_end, headers_done, request_done,
                    error_code, input ready);
    modport sink   (input valid, byte_out, part, field_end, headers_done, request_done,
                    error_code, output ready);
endinterface

FILE: hw/rtl/hrbp_core.sv
// Parser state and one-byte next-state logic; produces one result per transfer.
// Depends on hrbp_pkg.
`timescale 1ns / 1ps
module hrbp_core #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic                 i_command,
    input  logic [7:0]           i_data_byte,
    input  logic [31:0]          i_max_body,
    output hrbp_pkg::t_result    o_result
);
    import hrbp_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
    localparam logic [COUNT_WIDTH-1:0] HEX_LIM = CNT_MAX >> 4;
    localparam logic [COUNT_WIDTH-1:0] DEC_LIM = CNT_MAX / 10;
    localparam logic [3:0] DEC_REM = 4'(CNT_MAX % 10);
    localparam int MW = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

    logic [3:0]             r_phase, n_phase;
    logic [1:0]             r_ck, n_ck;
    logic                   r_fcr, n_fcr, r_line, n_line, r_colon, n_colon;
    logic [4:0]             r_npos, n_npos;
    logic [3:0]             r_nflg, n_nflg;
    logic [COUNT_WIDTH-1:0] r_vacc, n_vacc;
    logic [1:0]             r_vds, n_vds;
    logic [2:0]             r_cpos, n_cpos;
    logic                   r_lpres, n_lpres, r_lval, n_lval, r_chk, n_chk;
    logic [COUNT_WIDTH-1:0] r_len, n_len, r_body, n_body, r_hacc, n_hacc, r_crem, n_crem;
    logic [1:0]             r_hds, n_hds;

    logic [7:0] c, lc;
    logic       ws, dig, ishex;
    logic [3:0] dval, hval;
    logic [MW-1:0] len_w, body_w, max_w;
    logic [COUNT_WIDTH-1:0] body_inc;

    assign c   = i_data_byte;
    assign lc  = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    assign ws  = (c == " ") || (c == 8'h09);
    assign dig = (c >= "0") && (c <= "9");
    assign dval = 4'(c - "0");
    assign len_w  = MW'(r_len);
    assign body_w = MW'(r_body);
    assign max_w  = MW'(i_max_body);
    assign body_inc = r_body + 1'b1;

    always_comb begin
        ishex = 1'b1;
        hval  = 4'd0;
        if (dig) begin
            hval = dval;
        end else if (c >= "a" && c <= "f") begin
            hval = 4'(c - "a" + 8'd10);
        end else if (c >= "A" && c <= "F") begin
            hval = 4'(c - "A" + 8'd10);
        end else begin
            ishex = 1'b0;
        end
    end

    always_comb begin
        n_phase = r_phase; n_ck = r_ck; n_fcr = r_fcr; n_line = r_line;
        n_colon = r_colon; n_npos = r_npos; n_nflg = r_nflg; n_vacc = r_vacc;
        n_vds = r_vds; n_cpos = r_cpos; n_lpres = r_lpres; n_lval = r_lval;
        n_chk = r_chk; n_len = r_len; n_body = r_body; n_hacc = r_hacc;
        n_hds = r_hds; n_crem = r_crem;
        o_result = '0;
        o_result.byte_out = c;
        if (i_command) begin
            o_result = '0;
            n_phase = PH_METHOD; n_ck = CK_SIZE; n_fcr = 1'b0; n_line = 1'b0;
            n_colon = 1'b0; n_npos = '0; n_nflg = '0; n_vacc = '0; n_vds = '0;
            n_cpos = '0; n_lpres = 1'b0; n_lval = 1'b0; n_chk = 1'b0; n_len = '0;
            n_body = '0; n_hacc = '0; n_hds = '0; n_crem = '0;
        end else begin
            case (r_phase)
                PH_METHOD: begin
                    if (c == " ") begin
                        o_result.field_end = 1'b1; n_phase = PH_PATH;
                    end else o_result.part = PART_METHOD;
                end
                PH_PATH: begin
                    if (c == " ") begin
                        o_result.field_end = 1'b1; n_phase = PH_VERSION;
                    end else if (c == "?") begin
                        o_result.field_end = 1'b1; n_phase = PH_QUERY;
                    end else o_result.part = PART_PATH;
                end
                PH_QUERY: begin
                    if (c == " ") begin
                        o_result.field_end = 1'b1; n_phase = PH_VERSION;
                    end else o_result.part = PART_QUERY;
                end
                PH_VERSION: begin
                    if (c == 8'h0A) begin
                        o_result.field_end = 1'b1; n_phase = PH_HEADER;
                        n_line = 1'b0; n_colon = 1'b0; n_npos = '0; n_nflg = '0;
                        n_vacc = '0; n_vds = '0; n_cpos = '0;
                    end else if (c != 8'h0D) o_result.part = PART_VERSION;
                end
                PH_HEADER: begin
                    if (c == 8'h0D) begin
                    end else if (c == 8'h0A) begin
                        n_line = 1'b0; n_colon = 1'b0; n_npos = '0; n_nflg = '0;
                        n_vacc = '0; n_vds = '0; n_cpos = '0;
                        if (r_line) begin
                            o_result.field_end = 1'b1;
                            if (r_colon && r_nflg[0]) n_chk = (r_cpos >= 3'(LEN_CK));
                            if (r_colon && r_nflg[1]) begin
                                n_lpres = 1'b1; n_len = r_vacc;
                                n_lval = (r_vds == 2'd1) || (r_vds == 2'd2);
                            end
                        end else begin
                            o_result.headers_done = 1'b1;
                            if (r_chk) begin
                                n_phase = PH_CHUNKED; n_ck = CK_SIZE; n_hacc = '0;
                                n_hds = '0; n_crem = '0; n_fcr = 1'b0;
                            end else if (r_lpres) begin
                                if (!r_lval) begin
                                    o_result.error_code = ERR_LENGTH; n_phase = PH_ERROR;
                                end else if (len_w > max_w) begin
                                    o_result.error_code = ERR_SIZE; n_phase = PH_ERROR;
                                end else if (r_len != '0) begin
                                    n_body = '0; n_phase = PH_BODY;
                                end else begin
                                    o_result.request_done = 1'b1; n_phase = PH_DONE;
                                end
                            end else begin
                                o_result.request_done = 1'b1; n_phase = PH_DONE;
                            end
                        end
                    end else begin
                        n_line = 1'b1;
                        if (!r_colon) begin
                            if (c == ":") begin
                                n_nflg = {2'b00,
                                          !r_nflg[1] && (r_npos == 5'(LEN_CL)),
                                          !r_nflg[0] && (r_npos == 5'(LEN_TE))};
                                n_colon = 1'b1;
                            end else begin
                                o_result.part = PART_HNAME;
                                if (ws) begin
                                    if (r_npos != '0) n_nflg[2] = 1'b1;
                                end else begin
                                    if (r_nflg[2]) n_nflg[1:0] = 2'b11;
                                    else begin
                                        if (r_npos >= 5'(LEN_TE) || lc != te_char(r_npos))
                                            n_nflg[0] = 1'b1;
                                        if (r_npos >= 5'(LEN_CL) || lc != cl_char(r_npos))
                                            n_nflg[1] = 1'b1;
                                    end
                                    if (r_npos < 5'd31) n_npos = r_npos + 5'd1;
                                end
                            end
                        end else begin
                            o_result.part = PART_HVALUE;
                            if (r_nflg[0] && r_cpos < 3'(LEN_CK)) begin
                                if (c == ck_char(r_cpos)) n_cpos = r_cpos + 3'd1;
                                else n_cpos = (c == "c") ? 3'd1 : 3'd0;
                            end
                            if (r_nflg[1]) begin
                                case (r_vds)
                                    2'd0: begin
                                        if (dig) begin
                                            n_vacc = COUNT_WIDTH'(dval); n_vds = 2'd1;
                                        end else if (!ws) n_vds = 2'd3;
                                    end
                                    2'd1: begin
                                        if (dig) begin
                                            if (r_vacc > DEC_LIM ||
                                                (r_vacc == DEC_LIM && dval > DEC_REM))
                                                n_vacc = CNT_MAX;
                                            else
                                                n_vacc = (r_vacc << 3) + (r_vacc << 1)
                                                         + COUNT_WIDTH'(dval);
                                        end else n_vds = ws ? 2'd2 : 2'd3;
                                    end
                                    2'd2: if (!ws) n_vds = 2'd3;
                                    default: ;
                                endcase
                            end
                        end
                    end
                end
                PH_BODY: begin
                    if (body_w >= max_w) begin
                        o_result.error_code = ERR_SIZE; n_phase = PH_ERROR;
                    end else begin
                        o_result.part = PART_BODY;
                        n_body = body_inc;
                        if (body_inc >= r_len) begin
                            o_result.request_done = 1'b1; n_phase = PH_DONE;
                        end
                    end
                end
                PH_CHUNKED: begin
                    if (r_ck == CK_DATA) begin
                        o_result.part = PART_BODY;
                        if (r_crem <= COUNT_WIDTH'(1)) begin
                            n_crem = '0; n_ck = CK_SIZE;
                        end else n_crem = r_crem - 1'b1;
                    end else if (r_ck == CK_TRAILER) begin
                        if (c == 8'h0D) n_fcr = 1'b1;
                        else if (c == 8'h0A) begin
                            if (r_fcr && !r_line) begin
                                o_result.request_done = 1'b1; n_phase = PH_DONE;
                            end
                            n_line = 1'b0; n_fcr = 1'b0;
                        end else begin
                            n_line = 1'b1; n_fcr = 1'b0;
                        end
                    end else begin
                        if (c == 8'h0D) begin
                        end else if (c == 8'h0A) begin
                            if (r_hds == 2'd3) begin
                                o_result.error_code = ERR_LENGTH; n_phase = PH_ERROR;
                            end else if (r_hds != 2'd0) begin
                                if (r_hacc == '0) begin
                                    n_ck = CK_TRAILER; n_fcr = 1'b0; n_line = 1'b0;
                                end else begin
                                    n_crem = r_hacc; n_ck = CK_DATA;
                                end
                            end
                            n_hacc = '0; n_hds = '0;
                        end else if (r_hds == 2'd0) begin
                            if (ishex) begin
                                n_hacc = COUNT_WIDTH'(hval); n_hds = 2'd1;
                            end else n_hds = 2'd3;
                        end else if (r_hds == 2'd1) begin
                            if (ishex) n_hacc = (r_hacc > HEX_LIM) ? CNT_MAX
                                               : ((r_hacc << 4) | COUNT_WIDTH'(hval));
                            else n_hds = 2'd2;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_METHOD; r_ck <= CK_SIZE; r_fcr <= 1'b0; r_line <= 1'b0;
            r_colon <= 1'b0; r_npos <= '0; r_nflg <= '0; r_vacc <= '0; r_vds <= '0;
            r_cpos <= '0; r_lpres <= 1'b0; r_lval <= 1'b0; r_chk <= 1'b0; r_len <= '0;
            r_body <= '0; r_hacc <= '0; r_hds <= '0; r_crem <= '0;
        end else if (i_step) begin
            r_phase <= n_phase; r_ck <= n_ck; r_fcr <= n_fcr; r_line <= n_line;
            r_colon <= n_colon; r_npos <= n_npos; r_nflg <= n_nflg; r_vacc <= n_vacc;
            r_vds <= n_vds; r_cpos <= n_cpos; r_lpres <= n_lpres; r_lval <= n_lval;
            r_chk <= n_chk; r_len <= n_len; r_body <= n_body; r_hacc <= n_hacc;
            r_hds <= n_hds; r_crem <= n_crem;
        end
    end
endmodule

FILE: hw/rtl/hrbp_out_reg.sv
// Output result register with a skid stage so the input can take one more result under stall.
// Depends on hrbp_pkg.
`timescale 1ns / 1ps
module hrbp_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  hrbp_pkg::t_result i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output hrbp_pkg::t_result o_data
);
    import hrbp_pkg::*;

    logic    r_valid, r_skid_valid;
    t_result r_data, r_skid;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_valid || i_ready) begin
                r_valid <= r_skid_valid || i_valid;
                r_skid_valid <= 1'b0;
            end else if (i_valid && o_ready) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_valid || i_ready) begin
            r_data <= r_skid_valid ? r_skid : i_data;
        end else if (i_valid && o_ready) begin
            r_skid <= i_data;
        end
    end
endmodule

FILE: hw/rtl/http_request_byte_parser_top.sv
// Throughput: 1 byte per cycle while the output is not stalled; results are registered.
// The next state and the result are computed combinationally from registered state.
// A two-entry output stage keeps input ready while one result waits.
// Reset (i_rst_n low, synchronous) clears parser state and sets the body limit to 1048576.
// Top level of the HTTP request byte parser; depends on hrbp_pkg, hrbp_if,
// hrbp_core and hrbp_out_reg.
`timescale 1ns / 1ps
module http_request_byte_parser_top #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    hrbp_in_if.sink     i_in,
    hrbp_out_if.source  o_out
);
    import hrbp_pkg::*;

    logic [31:0] r_max_body;
    logic        step;
    t_result     result, out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_max_body <= MAX_BODY_RESET;
        else if (i_cfg_we) r_max_body <= i_cfg_wdata;
    end

    assign step = i_in.valid && i_in.ready;

    hrbp_core #(.COUNT_WIDTH(COUNT_WIDTH)) u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(step),
        .i_command(i_in.command), .i_data_byte(i_in.data_byte),
        .i_max_body(r_max_body), .o_result(result)
    );

    hrbp_out_reg u_out (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_in.valid), .o_ready(i_in.ready), .i_data(result),
        .o_valid(o_out.valid), .i_ready(o_out.ready), .o_data(out_data)
    );

    assign o_out.byte_out     = out_data.byte_out;
    assign o_out.part         = out_data.part;
    assign o_out.field_end    = out_data.field_end;
    assign o_out.headers_done = out_data.headers_done;
    assign o_out.request_done = out_data.request_done;
    assign o_out.error_code   = out_data.error_code;
endmodule

FILE: hw/rtl/hrbp_checker.sv
// Port-level checks for the parser top level, attached with bind.
// Depends on hrbp_pkg.
`timescale 1ns / 1ps
module hrbp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] out_part,
    input logic       out_field_end,
    input logic       out_headers_done,
    input logic       out_request_done,
    input logic [1:0] out_error_code
);
    import hrbp_pkg::*;

    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_error_code != 2'd3) else $error("bad error code");
    a_err_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_error_code != ERR_NONE |-> out_part == PART_FRAME
            && !out_request_done) else $error("error with tag");
    a_done_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_headers_done |-> out_part == PART_FRAME && !out_field_end)
        else $error("headers_done on tagged byte");
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_ready |-> out_valid) else $error("input stalled with empty output");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule

bind http_request_byte_parser_top hrbp_checker u_hrbp_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_ready(i_in.ready),
    .out_valid(o_out.valid), .out_ready(o_out.ready), .out_part(o_out.part),
    .out_field_end(o_out.field_end), .out_headers_done(o_out.headers_done),
    .out_request_done(o_out.request_done), .out_error_code(o_out.error_code)
);
